FILE: hw/rtl/ffba_pkg.sv
// Shared types, codes and defaults for the first-fit block allocator.
package ffba_pkg;

	localparam int MAX_BLOCKS_DEF      = 64;
	localparam int HDR_SIZE_DEF        = 48;
	localparam int ALIGN_BYTES_DEF     = 16;
	localparam int MIN_SPLIT_BYTES_DEF = 32;
	localparam logic [31:0] HEAP_BYTES_RESET = 32'd1048576;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_RESIZE  = 2'd2,
		OP_NONE    = 2'd3
	} ffba_op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NO_FIT  = 3'd1,
		ST_BAD     = 3'd2,
		ST_ALREADY = 3'd3,
		ST_ZERO    = 3'd4
	} ffba_status_t;

	typedef enum logic [1:0] {
		MD_ALLOC,
		MD_REL,
		MD_RSZ,
		MD_MOVE
	} ffba_mode_t;

	typedef enum logic [4:0] {
		S_IDLE, S_RND, S_DISP0, S_F_RD, S_F_EV, S_NX_RD, S_NX_EV, S_DISP,
		S_REL_W, S_REL_P, S_GROW_W, S_FT_RD, S_FT_EV, S_SP_CHK, S_UP_RD,
		S_UP_WR, S_SP_W, S_SP_END, S_RM_RD, S_RM_WR, S_SUM0, S_S_RD, S_S_EV,
		S_OUT
	} ffba_state_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
		logic        free;
	} ffba_entry_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] request_bytes;
		logic [31:0] addr;
	} ffba_req_t;

	typedef struct packed {
		logic [31:0] result_addr;
		logic [2:0]  status;
		logic        moved;
		logic [31:0] copy_bytes;
		logic [31:0] used_bytes;
		logic [31:0] avail_bytes;
	} ffba_rsp_t;

endpackage

FILE: hw/rtl/ffba_table.sv
// Block table memory: one write port, one registered read port.
module ffba_table #(
	parameter int DEPTH = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int IW    = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [IW-1:0]         waddr,
	input  ffba_pkg::ffba_entry_t wdata,
	input  logic [IW-1:0]         raddr,
	output ffba_pkg::ffba_entry_t rdata
);

	ffba_pkg::ffba_entry_t mem [DEPTH];
	ffba_pkg::ffba_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/ffba_round.sv
// Round-up of a request to the alignment (a power of two), registered.
module ffba_round #(
	parameter int ALIGN_BYTES = ffba_pkg::ALIGN_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] req_bytes,
	output logic        done,
	output logic [32:0] want
);

	localparam logic [32:0] AMASK = 33'(ALIGN_BYTES - 1);

	logic [32:0] want_q;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			want_q <= ({1'b0, req_bytes} + AMASK) & ~AMASK;
		end
	end

	assign done = done_q;
	assign want = want_q;

endmodule

FILE: hw/rtl/first_fit_block_allocator.sv
// First-fit block allocator: top level with sequencer and compare/add datapath.
// Usage: pulse start with a request on req while busy is low; the request is
// taken at that edge. Ops: allocate, release, resize. Exactly one result per
// request appears on rsp for one cycle with done high; the receiver must take
// it then, it cannot stall the block. busy stays high until the result shows.
// Steps: alignment rounding (alignment is a power of two), then table walks
// through the single read port of the block table: a search, any shift for
// inserting or removing an entry, and a final pass summing used and free
// bytes over all blocks. A request with no search (op 3, zero size, release
// of none) goes from rounding straight to the summing pass.
// One request at a time; the next can be taken in the cycle done is high.
// cfg_we/cfg_wdata set the arena length; the write drops all blocks and the
// table is rebuilt once the sequencer is idle (busy stays high until then).
// After reset the arena is 1048576 bytes with one free block, and busy is
// high for one cycle while that block is written.
module first_fit_block_allocator #(
	parameter int MAX_BLOCKS      = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int HDR_SIZE        = ffba_pkg::HDR_SIZE_DEF,
	parameter int ALIGN_BYTES     = ffba_pkg::ALIGN_BYTES_DEF,
	parameter int MIN_SPLIT_BYTES = ffba_pkg::MIN_SPLIT_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ffba_pkg::ffba_req_t req,
	output logic                done,
	output ffba_pkg::ffba_rsp_t rsp,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [31:0] H32  = 32'(HDR_SIZE);
	localparam logic [32:0] H33  = 33'(HDR_SIZE);
	localparam logic [33:0] H34  = 34'(HDR_SIZE);
	localparam logic [33:0] MS34 = 34'(MIN_SPLIT_BYTES);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

	ffba_pkg::ffba_state_t state_q, state_d, ret_q;
	ffba_pkg::ffba_mode_t  mode_q;
	logic [CW-1:0] cnt_q, k_q, idx_q;
	logic          init_q, done_q;
	logic [31:0]   heap_q;

	logic [1:0]    op_q;
	logic [31:0]   reqb_q, addr_q, old_q, res_q, copy_q, used_q, free_q;
	logic [32:0]   want_q;
	logic [2:0]    status_q;
	logic          moved_q, nxt_ok_q, sp_ok_q;
	ffba_pkg::ffba_entry_t cur_q, prv_q, nxt_q;
	ffba_pkg::ffba_rsp_t   rsp_q;

	logic          tbl_we;
	logic [IW-1:0] tbl_waddr, tbl_raddr;
	ffba_pkg::ffba_entry_t tbl_wdata, e;

	logic          accept, rnd_done;
	logic [32:0]   rnd_want;
	logic          alloc_like, rel_like, f_hit, rsz_fit, ft_hit, nxt_merge;
	logic          grow_ok, split_ok, prv_merge, heap_fits;
	logic [31:0]   merged;
	logic [CW-1:0] idx1, kp1;

	assign busy   = (state_q != ffba_pkg::S_IDLE) || init_q;
	assign accept = start && !busy;

	ffba_table #(.DEPTH(MAX_BLOCKS), .IW(IW)) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.raddr(tbl_raddr),
		.rdata(e)
	);

	ffba_round #(.ALIGN_BYTES(ALIGN_BYTES)) u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (accept),
		.req_bytes(req.request_bytes),
		.done     (rnd_done),
		.want     (rnd_want)
	);

	assign alloc_like = (op_q == ffba_pkg::OP_ALLOC) ||
		((op_q == ffba_pkg::OP_RESIZE) && (addr_q == '0));
	assign rel_like = (op_q == ffba_pkg::OP_RELEASE) ||
		((op_q == ffba_pkg::OP_RESIZE) && (reqb_q == '0));
	assign f_hit     = ({1'b0, e.start} + H33) == {1'b0, addr_q};
	assign rsz_fit   = {1'b0, e.size} >= want_q;
	assign ft_hit    = e.free && ({1'b0, e.size} >= want_q);
	assign nxt_merge = nxt_ok_q && nxt_q.free;
	assign grow_ok   = nxt_merge &&
		(({2'b0, cur_q.size} + H34 + {2'b0, nxt_q.size}) >= {1'b0, want_q});
	assign merged    = cur_q.size + H32 + nxt_q.size;
	assign split_ok  = (cnt_q < MAXC) &&
		({2'b0, cur_q.size} >= ({1'b0, want_q} + H34 + MS34));
	assign prv_merge = (idx_q != '0) && prv_q.free;
	assign heap_fits = {2'b0, heap_q} > (H34 + MS34);
	assign idx1      = idx_q + CW'(1);
	assign kp1       = k_q + CW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffba_pkg::S_IDLE:  if (accept) state_d = ffba_pkg::S_RND;
			ffba_pkg::S_RND:   if (rnd_done) state_d = ffba_pkg::S_DISP0;
			ffba_pkg::S_DISP0: begin
				priority if (op_q == ffba_pkg::OP_NONE) state_d = ffba_pkg::S_SUM0;
				else if (alloc_like)
					state_d = (reqb_q == '0) ? ffba_pkg::S_SUM0 : ffba_pkg::S_FT_RD;
				else if (rel_like)
					state_d = (addr_q == '0) ? ffba_pkg::S_SUM0 : ffba_pkg::S_F_RD;
				else state_d = ffba_pkg::S_F_RD;
			end
			ffba_pkg::S_F_RD:
				state_d = (k_q == cnt_q) ? ffba_pkg::S_SUM0 : ffba_pkg::S_F_EV;
			ffba_pkg::S_F_EV: begin
				priority if (!f_hit) state_d = ffba_pkg::S_F_RD;
				else if (e.free) state_d = ffba_pkg::S_SUM0;
				else if (mode_q == ffba_pkg::MD_RSZ && rsz_fit) state_d = ffba_pkg::S_SP_CHK;
				else state_d = ffba_pkg::S_NX_RD;
			end
			ffba_pkg::S_NX_RD:
				state_d = (idx1 < cnt_q) ? ffba_pkg::S_NX_EV : ffba_pkg::S_DISP;
			ffba_pkg::S_NX_EV: state_d = ffba_pkg::S_DISP;
			ffba_pkg::S_DISP: begin
				priority if (mode_q == ffba_pkg::MD_REL) state_d = ffba_pkg::S_REL_W;
				else if (grow_ok) state_d = ffba_pkg::S_GROW_W;
				else state_d = ffba_pkg::S_FT_RD;
			end
			ffba_pkg::S_REL_W:
				state_d = nxt_merge ? ffba_pkg::S_RM_RD : ffba_pkg::S_REL_P;
			ffba_pkg::S_REL_P:
				state_d = prv_merge ? ffba_pkg::S_RM_RD : ffba_pkg::S_SUM0;
			ffba_pkg::S_GROW_W: state_d = ffba_pkg::S_RM_RD;
			ffba_pkg::S_FT_RD:
				state_d = (k_q == cnt_q) ? ffba_pkg::S_SUM0 : ffba_pkg::S_FT_EV;
			ffba_pkg::S_FT_EV:
				state_d = ft_hit ? ffba_pkg::S_SP_CHK : ffba_pkg::S_FT_RD;
			ffba_pkg::S_SP_CHK:
				state_d = split_ok ? ffba_pkg::S_UP_RD : ffba_pkg::S_SP_W;
			ffba_pkg::S_UP_RD:
				state_d = (k_q == idx1) ? ffba_pkg::S_SP_W : ffba_pkg::S_UP_WR;
			ffba_pkg::S_UP_WR: state_d = ffba_pkg::S_UP_RD;
			ffba_pkg::S_SP_W:  state_d = ffba_pkg::S_SP_END;
			ffba_pkg::S_SP_END:
				state_d = (mode_q == ffba_pkg::MD_MOVE) ? ffba_pkg::S_F_RD : ffba_pkg::S_SUM0;
			ffba_pkg::S_RM_RD:
				state_d = (kp1 >= cnt_q) ? ret_q : ffba_pkg::S_RM_WR;
			ffba_pkg::S_RM_WR: state_d = ffba_pkg::S_RM_RD;
			ffba_pkg::S_SUM0:  state_d = ffba_pkg::S_S_RD;
			ffba_pkg::S_S_RD:
				state_d = (k_q == cnt_q) ? ffba_pkg::S_OUT : ffba_pkg::S_S_EV;
			ffba_pkg::S_S_EV:  state_d = ffba_pkg::S_S_RD;
			ffba_pkg::S_OUT:   state_d = ffba_pkg::S_IDLE;
			default:           state_d = ffba_pkg::S_IDLE;
		endcase
	end

	// table port control
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = idx_q[IW-1:0];
		tbl_wdata = cur_q;
		tbl_raddr = k_q[IW-1:0];
		unique case (state_q)
			ffba_pkg::S_IDLE: begin
				if (init_q && heap_fits) begin
					tbl_we    = 1'b1;
					tbl_waddr = '0;
					tbl_wdata = '{start: 32'd0, size: heap_q - H32, free: 1'b1};
				end
			end
			ffba_pkg::S_NX_RD: tbl_raddr = idx1[IW-1:0];
			ffba_pkg::S_REL_W: begin
				tbl_we    = 1'b1;
				tbl_wdata = '{start: cur_q.start, size: nxt_merge ? merged : cur_q.size,
					free: 1'b1};
			end
			ffba_pkg::S_REL_P: begin
				tbl_we    = prv_merge;
				tbl_waddr = IW'(idx_q - CW'(1));
				tbl_wdata = '{start: prv_q.start, size: prv_q.size + H32 + cur_q.size,
					free: 1'b1};
			end
			ffba_pkg::S_GROW_W: begin
				tbl_we    = 1'b1;
				tbl_wdata = '{start: cur_q.start, size: merged, free: 1'b0};
			end
			ffba_pkg::S_UP_RD: begin
				tbl_raddr = IW'(k_q - CW'(1));
				if (k_q == idx1) begin
					tbl_we    = 1'b1;
					tbl_waddr = idx1[IW-1:0];
					tbl_wdata = '{start: cur_q.start + H32 + want_q[31:0],
						size: cur_q.size - want_q[31:0] - H32, free: 1'b1};
				end
			end
			ffba_pkg::S_UP_WR, ffba_pkg::S_RM_WR: begin
				tbl_we    = 1'b1;
				tbl_waddr = k_q[IW-1:0];
				tbl_wdata = e;
			end
			ffba_pkg::S_SP_W: begin
				tbl_we    = 1'b1;
				tbl_wdata = '{start: cur_q.start, size: sp_ok_q ? want_q[31:0] : cur_q.size,
					free: 1'b0};
			end
			ffba_pkg::S_RM_RD: tbl_raddr = kp1[IW-1:0];
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::S_IDLE;
			ret_q   <= ffba_pkg::S_SUM0;
			mode_q  <= ffba_pkg::MD_ALLOC;
			cnt_q   <= '0;
			k_q     <= '0;
			init_q  <= 1'b1;
			heap_q  <= ffba_pkg::HEAP_BYTES_RESET;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ffba_pkg::S_OUT);
			if (cfg_we) begin
				heap_q <= cfg_wdata;
				init_q <= 1'b1;
			end else if (state_q == ffba_pkg::S_IDLE && init_q) begin
				init_q <= 1'b0;
				cnt_q  <= heap_fits ? CW'(1) : '0;
			end
			unique case (state_q)
				ffba_pkg::S_DISP0: begin
					k_q <= '0;
					priority if (alloc_like) mode_q <= ffba_pkg::MD_ALLOC;
					else if (rel_like) mode_q <= ffba_pkg::MD_REL;
					else mode_q <= ffba_pkg::MD_RSZ;
				end
				ffba_pkg::S_F_EV: if (!f_hit) k_q <= kp1;
				ffba_pkg::S_DISP: begin
					if (mode_q == ffba_pkg::MD_RSZ && !grow_ok) begin
						mode_q <= ffba_pkg::MD_MOVE;
						k_q    <= '0;
					end
				end
				ffba_pkg::S_REL_W: begin
					k_q   <= idx1;
					ret_q <= ffba_pkg::S_REL_P;
				end
				ffba_pkg::S_REL_P: begin
					k_q   <= idx_q;
					ret_q <= ffba_pkg::S_SUM0;
				end
				ffba_pkg::S_GROW_W: begin
					k_q   <= idx1;
					ret_q <= ffba_pkg::S_SP_CHK;
				end
				ffba_pkg::S_FT_EV: if (!ft_hit) k_q <= kp1;
				ffba_pkg::S_SP_CHK: k_q <= cnt_q;
				ffba_pkg::S_UP_RD: if (k_q == idx1) cnt_q <= cnt_q + CW'(1);
				ffba_pkg::S_UP_WR: k_q <= k_q - CW'(1);
				ffba_pkg::S_SP_END: begin
					if (mode_q == ffba_pkg::MD_MOVE) begin
						mode_q <= ffba_pkg::MD_REL;
						k_q    <= '0;
					end
				end
				ffba_pkg::S_RM_RD: if (kp1 >= cnt_q) cnt_q <= cnt_q - CW'(1);
				ffba_pkg::S_RM_WR: k_q <= kp1;
				ffba_pkg::S_SUM0:  k_q <= '0;
				ffba_pkg::S_S_EV:  k_q <= kp1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ffba_pkg::S_IDLE: begin
				if (accept) begin
					op_q     <= req.op;
					reqb_q   <= req.request_bytes;
					addr_q   <= req.addr;
					res_q    <= '0;
					status_q <= ffba_pkg::ST_OK;
					moved_q  <= 1'b0;
					copy_q   <= '0;
				end
			end
			ffba_pkg::S_RND: if (rnd_done) want_q <= rnd_want;
			ffba_pkg::S_DISP0: begin
				if (op_q != ffba_pkg::OP_NONE && alloc_like && reqb_q == '0)
					status_q <= ffba_pkg::ST_ZERO;
			end
			ffba_pkg::S_F_RD: if (k_q == cnt_q) status_q <= ffba_pkg::ST_BAD;
			ffba_pkg::S_F_EV: begin
				if (f_hit) begin
					idx_q <= k_q;
					cur_q <= e;
					old_q <= e.size;
					if (e.free) status_q <= ffba_pkg::ST_ALREADY;
				end else begin
					prv_q <= e;
				end
			end
			ffba_pkg::S_NX_RD: nxt_ok_q <= 1'b0;
			ffba_pkg::S_NX_EV: begin
				nxt_q    <= e;
				nxt_ok_q <= 1'b1;
			end
			ffba_pkg::S_REL_W: if (nxt_merge) cur_q.size <= merged;
			ffba_pkg::S_GROW_W: cur_q.size <= merged;
			ffba_pkg::S_FT_RD: if (k_q == cnt_q) status_q <= ffba_pkg::ST_NO_FIT;
			ffba_pkg::S_FT_EV: begin
				if (ft_hit) begin
					idx_q <= k_q;
					cur_q <= e;
				end
			end
			ffba_pkg::S_SP_CHK: sp_ok_q <= split_ok;
			ffba_pkg::S_SP_END: begin
				unique case (mode_q)
					ffba_pkg::MD_RSZ: res_q <= addr_q;
					ffba_pkg::MD_MOVE: begin
						res_q   <= cur_q.start + H32;
						moved_q <= 1'b1;
						copy_q  <= (old_q < reqb_q) ? old_q : reqb_q;
					end
					default: res_q <= cur_q.start + H32;
				endcase
			end
			ffba_pkg::S_SUM0: begin
				used_q <= '0;
				free_q <= '0;
			end
			ffba_pkg::S_S_EV: begin
				if (e.free) free_q <= free_q + e.size;
				else used_q <= used_q + e.size;
			end
			ffba_pkg::S_OUT: begin
				rsp_q <= '{result_addr: res_q, status: status_q, moved: moved_q,
					copy_bytes: copy_q, used_bytes: used_q, avail_bytes: free_q};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAXC)
		else $error("block count above table depth");

	a_done_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == ffba_pkg::S_OUT)
		else $error("result strobe without output step");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("not busy after request transfer");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ffba_pkg::S_UP_WR |-> cnt_q < MAXC)
		else $error("insert shift with full table");

	a_remove_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ffba_pkg::S_RM_RD |-> cnt_q != '0)
		else $error("remove from empty table");

endmodule
